// ===== rtl/wpvs_pkg.sv =====
package wpvs_pkg;

   // fixed point and defaults
   localparam logic [47:0] Q_ONE           = 48'd16777216;
   localparam int          MAX_PATHS_DEF   = 1024;
   localparam int          MAX_PERIODS_DEF = 64;

   localparam logic [46:0] RISKFREE_RESET = 47'd16944988;
   localparam logic [46:0] DISCOUNT_RESET = 47'd16611105;
   localparam logic [47:0] PENALTY_RESET  = 48'd8388608;
   localparam logic [10:0] PATHS_RESET    = 11'd1;
   localparam logic [6:0]  PERIODS_RESET  = 7'd1;

   // register file
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;
   localparam logic [2:0] REG_RISKFREE = 3'd0;
   localparam logic [2:0] REG_DISCOUNT = 3'd1;
   localparam logic [2:0] REG_PENALTY  = 3'd2;
   localparam logic [2:0] REG_PATHS    = 3'd3;
   localparam logic [2:0] REG_PERIODS  = 3'd4;

   typedef struct packed {
      logic signed [47:0] initial_wealth;
      logic signed [47:0] risky_return;
      logic signed [47:0] share_const;
      logic signed [47:0] share_linear;
      logic signed [47:0] share_quad;
      logic signed [47:0] cons_offset;
      logic signed [47:0] cons_slope;
   } req_type;

   typedef struct packed {
      logic [9:0]         path_index;
      logic [5:0]         period_index;
      logic signed [47:0] risky_amount;
      logic signed [47:0] consumption;
      logic signed [47:0] new_wealth;
      logic               done_res;
      logic signed [63:0] mean_value;
   } rsp_type;

   // control toward the shared multiplier
   typedef struct packed {
      logic start;
      logic wide;
   } mul_req_type;

endpackage

// ===== rtl/wpvs_ram.sv =====
module wpvs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wpvs_mul.sv =====
module wpvs_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  wpvs_pkg::mul_req_type mul_req,
   input  logic [63:0]          op_a,
   input  logic [63:0]          op_b,
   output logic                 done,
   output logic [63:0]          result
);

   logic         busy_ff, busy_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [63:0]  ua_ff, ua_in, ub_ff, ub_in;
   logic         neg_ff, neg_in, wide_ff, wide_in;
   logic [127:0] acc_ff, acc_in;
   logic         done_ff, done_in;
   logic [63:0]  res_ff, res_in;

   logic [31:0]  a_part, b_part;
   logic [63:0]  pp;
   logic [127:0] pp_sh, rnd;
   logic [63:0]  mag, satv;
   logic         over;

   // one 32x32 partial product per cycle
   assign a_part = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign b_part = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
   assign pp     = a_part * b_part;

   always_comb begin
      case ({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]})
         2'd0:    pp_sh = {64'd0, pp};
         2'd1:    pp_sh = {32'd0, pp, 32'd0};
         default: pp_sh = {pp, 64'd0};
      endcase
   end

   // round half away from zero, then saturate to 48 or 64 bits
   assign rnd  = acc_ff + 128'h80_0000;
   assign mag  = rnd[87:24];
   assign over = (|rnd[127:88]) || (wide_ff ? mag[63] : (|mag[63:47]));
   always_comb begin
      if (neg_ff) begin
         satv = wide_ff ? 64'h8000_0000_0000_0000 : {{17{1'b1}}, 47'd0};
      end else begin
         satv = wide_ff ? 64'h7FFF_FFFF_FFFF_FFFF : {17'd0, {47{1'b1}}};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      wide_in = wide_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         ua_in   = op_a[63] ? (~op_a + 64'd1) : op_a;
         ub_in   = op_b[63] ? (~op_b + 64'd1) : op_b;
         neg_in  = op_a[63] ^ op_b[63];
         wide_in = mul_req.wide;
         acc_in  = 128'd0;
      end else if (busy_ff) begin
         if (cnt_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = over ? satv : (neg_ff ? (~mag + 64'd1) : mag);
         end else begin
            acc_in = acc_ff + pp_sh;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      wide_ff <= wide_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/wpvs_div.sv =====
module wpvs_div #(
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [63:0]   quotient
);

   logic          busy_ff, busy_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [63:0]   quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic          done_ff, done_in;
   logic [63:0]   res_ff, res_in;

   logic [DW:0]   rem_sh, diff;
   logic          ge;
   logic [63:0]   quo_nx;

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign diff   = rem_sh - {1'b0, div_ff};
   assign ge     = rem_sh >= {1'b0, div_ff};
   assign quo_nx = {quo_ff[62:0], ge};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend[63] ? (~dividend + 64'd1) : dividend;
         neg_in  = dividend[63];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
         quo_in = quo_nx;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (~quo_nx + 64'd1) : quo_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

// ===== rtl/wealth_path_value_simulator.sv =====
// one item at a time: each item runs 11 products through the shared 32x32 multiplier
// (four partial products, round, handoff each), plus one load, one result and one accept
// step; a result beat still untaken holds the next item's result until the receiver takes it
// items of the last period take three more products
// the final item of a run adds the bit-serial mean division
// synchronous active-high reset restores register defaults and starts a new run
module wealth_path_value_simulator #(
   parameter int MAX_PATHS   = wpvs_pkg::MAX_PATHS_DEF,
   parameter int MAX_PERIODS = wpvs_pkg::MAX_PERIODS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wpvs_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wpvs_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wpvs_pkg::CSR_AW-1:0]   paddr,
   input  logic [wpvs_pkg::CSR_DW-1:0]   pwdata,
   output logic [wpvs_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam int AW  = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
   localparam int TW  = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
   localparam int PcW = ($clog2(MAX_PATHS + 1) > 11) ? $clog2(MAX_PATHS + 1) : 11;
   localparam int TcW = ($clog2(MAX_PERIODS + 1) > 7) ? $clog2(MAX_PERIODS + 1) : 7;

   localparam logic [47:0] SIG_TOP = 48'd83886080;
   localparam logic [47:0] SIG_MID = 48'd39845888;
   localparam logic [47:0] OFS_TOP = 48'd14155776;
   localparam logic [47:0] OFS_MID = 48'd10485760;
   localparam logic [47:0] OFS_LOW = 48'd8388608;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_WAIT, ST_DIV, ST_DIVW, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_WW, OP_LIN, OP_QUAD, OP_SLOPE, OP_CONS, OP_RF, OP_RR, OP_WEIGHT,
      OP_SQ, OP_LAM, OP_ACC
   } op_type;

   // helpers
   function automatic logic [49:0] sx50(input logic [47:0] v);
      return {{2{v[47]}}, v};
   endfunction

   function automatic logic [63:0] sx64(input logic [47:0] v);
      return {{16{v[47]}}, v};
   endfunction

   function automatic logic [47:0] sat48(input logic [49:0] v);
      if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
         return v[47:0];
      end
      return v[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
   endfunction

   function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s[63:0];
   endfunction

   function automatic logic [63:0] sat63(input logic [63:0] v);
      if (v[63] == v[62]) begin
         return v;
      end
      return v[63] ? 64'hC000_0000_0000_0000 : 64'h3FFF_FFFF_FFFF_FFFF;
   endfunction

   // piecewise linear logistic
   function automatic logic [47:0] sigmoid(input logic [47:0] x);
      logic [47:0] ax, y;
      ax = x[47] ? (~x + 48'd1) : x;
      if (ax >= SIG_TOP) begin
         y = wpvs_pkg::Q_ONE;
      end else if (ax >= SIG_MID) begin
         y = (ax >> 5) + OFS_TOP;
      end else if (ax >= wpvs_pkg::Q_ONE) begin
         y = (ax >> 3) + OFS_MID;
      end else begin
         y = (ax >> 2) + OFS_LOW;
      end
      return x[47] ? (wpvs_pkg::Q_ONE - y) : y;
   endfunction

   // registers
   logic [46:0]       rf_ff, rf_in, df_ff, df_in;
   logic [47:0]       lam_ff, lam_in;
   logic [10:0]       pcnt_ff, pcnt_in;
   logic [6:0]        tcnt_ff, tcnt_in;
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic              term_ff, term_in;
   wpvs_pkg::req_type item_ff, item_in;
   logic [47:0]       w_ff, w_in, ww_ff, ww_in, tmp_ff, tmp_in, beta_ff, beta_in;
   logic [47:0]       sig_ff, sig_in, cons_ff, cons_in, nw_ff, nw_in, weight_ff, weight_in;
   logic [47:0]       dp_ff, dp_in;
   logic [63:0]       tmp64_ff, tmp64_in, util_ff, util_in, total_ff, total_in;
   logic [63:0]       mean_ff, mean_in;
   logic [AW-1:0]     path_ctr_ff, path_ctr_in;
   logic [TW-1:0]     per_ctr_ff, per_ctr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   wpvs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // datapath wires
   wpvs_pkg::mul_req_type mul_req;
   logic [63:0]   mul_a, mul_b, mul_res;
   logic          mul_done;
   logic          div_done;
   logic [63:0]   div_q;
   logic [47:0]   ram_rd, r48, c_sel, w_less_beta;
   logic          ram_we, out_go, cfg_wr;
   logic [PcW-1:0] pc_eff;
   logic [TcW-1:0] tc_eff;
   logic          last_path, last_period, last_item;

   // effective counts
   always_comb begin
      if (pcnt_ff == 11'd0) begin
         pc_eff = PcW'(1);
      end else if (PcW'(pcnt_ff) > PcW'(MAX_PATHS)) begin
         pc_eff = PcW'(MAX_PATHS);
      end else begin
         pc_eff = PcW'(pcnt_ff);
      end
      if (tcnt_ff == 7'd0) begin
         tc_eff = TcW'(1);
      end else if (TcW'(tcnt_ff) > TcW'(MAX_PERIODS)) begin
         tc_eff = TcW'(MAX_PERIODS);
      end else begin
         tc_eff = TcW'(tcnt_ff);
      end
   end

   assign last_path   = (PcW'(path_ctr_ff) + PcW'(1)) >= pc_eff;
   assign last_period = (TcW'(per_ctr_ff) + TcW'(1)) >= tc_eff;
   assign last_item   = last_path & last_period;

   // operand selection for the shared multiplier
   assign r48         = mul_res[47:0];
   assign c_sel       = term_ff ? nw_ff : cons_ff;
   assign w_less_beta = sat48(sx50(w_ff) - sx50(beta_ff));

   always_comb begin
      case (op_ff)
         OP_WW:     begin mul_a = sx64(w_ff);                  mul_b = sx64(w_ff); end
         OP_LIN:    begin mul_a = sx64(item_ff.share_linear);  mul_b = sx64(w_ff); end
         OP_QUAD:   begin mul_a = sx64(item_ff.share_quad);    mul_b = sx64(ww_ff); end
         OP_SLOPE:  begin mul_a = sx64(item_ff.cons_slope);    mul_b = sx64(w_ff); end
         OP_CONS:   begin mul_a = sx64(w_ff);                  mul_b = sx64(sig_ff); end
         OP_RF:     begin mul_a = sx64(w_less_beta);           mul_b = {17'd0, rf_ff}; end
         OP_RR:     begin mul_a = sx64(beta_ff);
                          mul_b = sx64(item_ff.risky_return); end
         OP_WEIGHT: begin mul_a = sx64(dp_ff);                 mul_b = {17'd0, df_ff}; end
         OP_SQ:     begin mul_a = sx64(c_sel);                 mul_b = sx64(c_sel); end
         OP_LAM:    begin mul_a = sx64(lam_ff);                mul_b = sx64(c_sel); end
         OP_ACC:    begin mul_a = sx64(weight_ff);             mul_b = util_ff; end
         default:   begin mul_a = 64'd0;                       mul_b = 64'd0; end
      endcase
   end

   assign mul_req.start = (state_ff == ST_MUL);
   assign mul_req.wide  = (op_ff == OP_SQ) || (op_ff == OP_LAM) || (op_ff == OP_ACC);

   wpvs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .result  (mul_res)
   );

   wpvs_div #(
      .DW (PcW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIV),
      .dividend (total_ff),
      .divisor  (pc_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   wpvs_ram #(
      .WIDTH (48),
      .DEPTH (MAX_PATHS)
   ) u_wealth (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (path_ctr_ff),
      .wr_data (nw_ff),
      .rd_addr (path_ctr_ff),
      .rd_data (ram_rd)
   );

   assign out_go = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign ram_we = out_go;
   assign cfg_wr = psel & penable & pwrite;

   // sequencer and register file
   always_comb begin
      rf_in        = rf_ff;
      df_in        = df_ff;
      lam_in       = lam_ff;
      pcnt_in      = pcnt_ff;
      tcnt_in      = tcnt_ff;
      state_in     = state_ff;
      op_in        = op_ff;
      term_in      = term_ff;
      item_in      = item_ff;
      w_in         = w_ff;
      ww_in        = ww_ff;
      tmp_in       = tmp_ff;
      beta_in      = beta_ff;
      sig_in       = sig_ff;
      cons_in      = cons_ff;
      nw_in        = nw_ff;
      weight_in    = weight_ff;
      dp_in        = dp_ff;
      tmp64_in     = tmp64_ff;
      util_in      = util_ff;
      total_in     = total_ff;
      mean_in      = mean_ff;
      path_ctr_in  = path_ctr_ff;
      per_ctr_in   = per_ctr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (cfg_wr) begin
         case (paddr[5:3])
            wpvs_pkg::REG_RISKFREE: rf_in   = pwdata[46:0];
            wpvs_pkg::REG_DISCOUNT: df_in   = pwdata[46:0];
            wpvs_pkg::REG_PENALTY:  lam_in  = pwdata[47:0];
            wpvs_pkg::REG_PATHS:    pcnt_in = pwdata[10:0];
            wpvs_pkg::REG_PERIODS:  tcnt_in = pwdata[6:0];
            default: ;
         endcase
      end

      // result beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               op_in    = OP_WW;
               term_in  = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            w_in     = (per_ctr_ff == '0) ? item_ff.initial_wealth : ram_rd;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               state_in = ST_MUL;
               case (op_ff)
                  OP_WW: begin
                     ww_in = r48;
                     op_in = OP_LIN;
                  end
                  OP_LIN: begin
                     tmp_in = r48;
                     op_in  = OP_QUAD;
                  end
                  OP_QUAD: begin
                     beta_in = sat48(sx50(item_ff.share_const) + sx50(tmp_ff) + sx50(r48));
                     op_in   = OP_SLOPE;
                  end
                  OP_SLOPE: begin
                     sig_in = sigmoid(sat48(sx50(item_ff.cons_offset) + sx50(r48)));
                     op_in  = OP_CONS;
                  end
                  OP_CONS: begin
                     cons_in = r48;
                     op_in   = OP_RF;
                  end
                  OP_RF: begin
                     tmp_in = r48;
                     op_in  = OP_RR;
                  end
                  OP_RR: begin
                     nw_in = sat48(sx50(tmp_ff) + sx50(r48) - sx50(cons_ff));
                     op_in = OP_WEIGHT;
                  end
                  OP_WEIGHT: begin
                     weight_in = r48;
                     op_in     = OP_SQ;
                  end
                  OP_SQ: begin
                     tmp64_in = mul_res;
                     op_in    = OP_LAM;
                  end
                  OP_LAM: begin
                     util_in = sadd64(sadd64(tmp64_ff, ~sat63(mul_res) + 64'd1),
                                      ~sat63(mul_res) + 64'd1);
                     op_in   = OP_ACC;
                  end
                  OP_ACC: begin
                     total_in = sadd64(total_ff, mul_res);
                     if (last_period && !term_ff) begin
                        // terminal wealth term
                        term_in = 1'b1;
                        op_in   = OP_SQ;
                     end else begin
                        state_in = last_item ? ST_DIV : ST_OUT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               mean_in  = div_q;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_go) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.path_index    = 10'(path_ctr_ff);
               rsp_data_in.period_index  = 6'(per_ctr_ff);
               rsp_data_in.risky_amount  = beta_ff;
               rsp_data_in.consumption   = cons_ff;
               rsp_data_in.new_wealth    = nw_ff;
               rsp_data_in.done_res      = last_item;
               rsp_data_in.mean_value    = last_item ? mean_ff : 64'd0;
               // advance path and period
               if (last_item) begin
                  total_in    = 64'd0;
                  dp_in       = wpvs_pkg::Q_ONE;
                  path_ctr_in = '0;
                  per_ctr_in  = '0;
               end else if (last_path) begin
                  dp_in       = weight_ff;
                  path_ctr_in = '0;
                  per_ctr_in  = per_ctr_ff + TW'(1);
               end else begin
                  path_ctr_in = path_ctr_ff + AW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ff        <= wpvs_pkg::RISKFREE_RESET;
         df_ff        <= wpvs_pkg::DISCOUNT_RESET;
         lam_ff       <= wpvs_pkg::PENALTY_RESET;
         pcnt_ff      <= wpvs_pkg::PATHS_RESET;
         tcnt_ff      <= wpvs_pkg::PERIODS_RESET;
         state_ff     <= ST_IDLE;
         op_ff        <= OP_WW;
         term_ff      <= 1'b0;
         total_ff     <= 64'd0;
         dp_ff        <= wpvs_pkg::Q_ONE;
         path_ctr_ff  <= '0;
         per_ctr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rf_ff        <= rf_in;
         df_ff        <= df_in;
         lam_ff       <= lam_in;
         pcnt_ff      <= pcnt_in;
         tcnt_ff      <= tcnt_in;
         state_ff     <= state_in;
         op_ff        <= op_in;
         term_ff      <= term_in;
         total_ff     <= total_in;
         dp_ff        <= dp_in;
         path_ctr_ff  <= path_ctr_in;
         per_ctr_ff   <= per_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      w_ff        <= w_in;
      ww_ff       <= ww_in;
      tmp_ff      <= tmp_in;
      beta_ff     <= beta_in;
      sig_ff      <= sig_in;
      cons_ff     <= cons_in;
      nw_ff       <= nw_in;
      weight_ff   <= weight_in;
      tmp64_ff    <= tmp64_in;
      util_ff     <= util_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register readback
   always_comb begin
      case (paddr[5:3])
         wpvs_pkg::REG_RISKFREE: prdata = {17'd0, rf_ff};
         wpvs_pkg::REG_DISCOUNT: prdata = {17'd0, df_ff};
         wpvs_pkg::REG_PENALTY:  prdata = sx64(lam_ff);
         wpvs_pkg::REG_PATHS:    prdata = {53'd0, pcnt_ff};
         wpvs_pkg::REG_PERIODS:  prdata = {57'd0, tcnt_ff};
         default:                prdata = 64'd0;
      endcase
   end

   assign pready    = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/tb_wealth_path_value_simulator.sv =====
`timescale 1ns / 1ps

module tb_wealth_path_value_simulator;

   localparam longint ONE_Q    = 64'sd16777216;
   localparam int     LIMIT    = 2000000;
   localparam int     DRAIN    = 250;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   wpvs_pkg::req_type             req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   wpvs_pkg::rsp_type             rsp_data;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [wpvs_pkg::CSR_AW-1:0]   paddr = '0;
   logic [wpvs_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [wpvs_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;

   wealth_path_value_simulator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // mirror of the block's registers and run state
   longint   rf_rate, disc_factor, lambda_w;
   int       paths_reg, periods_reg;
   longint   wealth_mem [1024];
   longint   util_total, disc_power;
   int       path_pos, period_pos;

   wpvs_pkg::rsp_type  pending_steps [$];
   int       error_count = 0;
   int       cycle_count = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   int       items_sent = 0;

   // clock and run limit
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic longint smax(int width);
      return longint'((64'd1 << (width - 1)) - 64'd1);
   endfunction

   function automatic longint clip(longint v, int width);
      if (v > smax(width)) return smax(width);
      if (v < -smax(width) - 1) return -smax(width) - 1;
      return v;
   endfunction

   function automatic longint add_sat64(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return smax(64);
      if (a < 0 && b < 0 && s >= 0) return -smax(64) - 1;
      return s;
   endfunction

   // exact product, round half away from zero, saturate to width bits
   function automatic longint fx_mul(longint a, longint b, int width);
      bit         neg;
      bit [63:0]  ua, ub;
      bit [127:0] m, lim;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
      ub = (b < 0) ? 64'd0 - 64'(b) : 64'(b);
      m = ({64'd0, ua} * {64'd0, ub} + 128'h800000) >> 24;
      lim = 128'd1 << (width - 1);
      if (neg) begin
         if (m >= lim) return -smax(width) - 1;
         return -longint'(m[63:0]);
      end
      if (m >= lim) return smax(width);
      return longint'(m[63:0]);
   endfunction

   function automatic longint logistic_approx(longint x);
      longint ax, y;
      ax = (x < 0) ? -x : x;
      if (ax >= 5 * ONE_Q) y = ONE_Q;
      else if (ax >= 39845888) y = (ax >>> 5) + 14155776;
      else if (ax >= ONE_Q) y = (ax >>> 3) + 10485760;
      else y = (ax >>> 2) + 8388608;
      return (x < 0) ? ONE_Q - y : y;
   endfunction

   // c^2 - 2*lambda*c
   function automatic longint quad_utility(longint c);
      longint sq, lc;
      sq = fx_mul(c, c, 64);
      lc = clip(fx_mul(lambda_w, c, 64), 63);
      return add_sat64(add_sat64(sq, -lc), -lc);
   endfunction

   function automatic int eff_paths();
      if (paths_reg == 0) return 1;
      return (paths_reg > 1024) ? 1024 : paths_reg;
   endfunction

   function automatic int eff_periods();
      if (periods_reg == 0) return 1;
      return (periods_reg > 64) ? 64 : periods_reg;
   endfunction

   // one simulated path step and its effect on the run state
   function automatic wpvs_pkg::rsp_type advance_path(wpvs_pkg::req_type it);
      wpvs_pkg::rsp_type r;
      int      pc, tc, p;
      bit      last_path, last_period;
      longint  w, beta, x, cons, nw, weight;
      pc = eff_paths();
      tc = eff_periods();
      p = path_pos % 1024;
      last_path = path_pos + 1 >= pc;
      last_period = period_pos + 1 >= tc;
      w = (period_pos == 0) ? longint'(it.initial_wealth) : wealth_mem[p];
      beta = clip(longint'(it.share_const) + fx_mul(it.share_linear, w, 48)
                  + fx_mul(it.share_quad, fx_mul(w, w, 48), 48), 48);
      x = clip(longint'(it.cons_offset) + fx_mul(it.cons_slope, w, 48), 48);
      cons = fx_mul(w, logistic_approx(x), 48);
      nw = clip(fx_mul(clip(w - beta, 48), rf_rate, 48)
                + fx_mul(beta, it.risky_return, 48) - cons, 48);
      wealth_mem[p] = nw;
      weight = fx_mul(disc_power, disc_factor, 48);
      util_total = add_sat64(util_total, fx_mul(weight, quad_utility(cons), 64));
      if (last_period)
         util_total = add_sat64(util_total, fx_mul(weight, quad_utility(nw), 64));
      r.path_index = p[9:0];
      r.period_index = period_pos[5:0];
      r.risky_amount = beta[47:0];
      r.consumption = cons[47:0];
      r.new_wealth = nw[47:0];
      r.done_res = last_path && last_period;
      r.mean_value = '0;
      if (last_path && last_period) begin
         r.mean_value = util_total / longint'(pc);
         util_total = 0;
         disc_power = ONE_Q;
         path_pos = 0;
         period_pos = 0;
      end else if (last_path) begin
         disc_power = weight;
         path_pos = 0;
         period_pos++;
      end else begin
         path_pos++;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // result checking, sampled at the falling edge before the accepting edge
   always @(negedge clock) begin
      wpvs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data.mean_value, 64'd0);
         end else begin
            want = pending_steps.pop_front();
            if (rsp_data.path_index !== want.path_index)
               report_mismatch("path_index", rsp_data.path_index, want.path_index);
            if (rsp_data.period_index !== want.period_index)
               report_mismatch("period_index", rsp_data.period_index, want.period_index);
            if (rsp_data.risky_amount !== want.risky_amount)
               report_mismatch("risky_amount", rsp_data.risky_amount, want.risky_amount);
            if (rsp_data.consumption !== want.consumption)
               report_mismatch("consumption", rsp_data.consumption, want.consumption);
            if (rsp_data.new_wealth !== want.new_wealth)
               report_mismatch("new_wealth", rsp_data.new_wealth, want.new_wealth);
            if (rsp_data.done_res !== want.done_res)
               report_mismatch("done_res", rsp_data.done_res, want.done_res);
            if (rsp_data.mean_value !== want.mean_value)
               report_mismatch("mean_value", rsp_data.mean_value, want.mean_value);
         end
      end
   end

   // one beat on the request channel
   task automatic send_step(wpvs_pkg::req_type it);
      bit taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      pending_steps.push_back(advance_path(it));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // apb write: setup then access
   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         wpvs_pkg::REG_RISKFREE: rf_rate = longint'(val[46:0]);
         wpvs_pkg::REG_DISCOUNT: disc_factor = longint'(val[46:0]);
         wpvs_pkg::REG_PENALTY:  lambda_w = longint'($signed(val[47:0]));
         wpvs_pkg::REG_PATHS:    paths_reg = int'(val[10:0]);
         wpvs_pkg::REG_PERIODS:  periods_reg = int'(val[6:0]);
         default: ;
      endcase
   endtask

   // mostly modest Q24.24 values, sometimes any 48 bit pattern or an extreme
   function automatic logic [47:0] rand_q(int span);
      case ($urandom_range(0, 19))
         0, 1: return 48'({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
         2: return 48'h7FFF_FFFF_FFFF;
         3: return 48'h8000_0000_0000;
         4: return 48'd0;
         default: return 48'(longint'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic wpvs_pkg::req_type rand_step();
      wpvs_pkg::req_type it;
      it.initial_wealth = rand_q(1 << 27);
      it.risky_return = 48'(ONE_Q + rand_q(1 << 22));
      it.share_const = rand_q(1 << 24);
      it.share_linear = rand_q(1 << 23);
      it.share_quad = rand_q(1 << 20);
      it.cons_offset = rand_q(1 << 27);
      it.cons_slope = rand_q(1 << 25);
      return it;
   endfunction

   // a complete run, period-major, random content
   task automatic send_run();
      int pc, tc;
      pc = eff_paths();
      tc = eff_periods();
      for (int t = 0; t < tc; t++)
         for (int p = 0; p < pc; p++) send_step(rand_step());
   endtask

   // field extremes and every segment of the sigmoid, one item per run
   task automatic test_directed();
      wpvs_pkg::req_type it;
      longint  xs [12];
      xs = '{0, 100, -100, ONE_Q, -ONE_Q, 39845888, -39845888, 39845887,
             5 * ONE_Q, -5 * ONE_Q, 5 * ONE_Q - 1, 48'sh7FFF_FFFF_FFFF};
      for (int i = 0; i < 12; i++) begin
         it = '0;
         it.initial_wealth = 48'(ONE_Q);
         it.risky_return = 48'(ONE_Q);
         it.share_const = 48'(ONE_Q >>> 1);
         it.cons_offset = 48'(xs[i]);
         send_step(it);
      end
      it = '1;
      send_step(it);
      it = '0;
      send_step(it);
      it = {7{48'h7FFF_FFFF_FFFF}};
      send_step(it);
      it = {7{48'h8000_0000_0000}};
      send_step(it);
      it = {7{48'hAAAA_AAAA_AAAA}};
      send_step(it);
      it = {7{48'h5555_5555_5555}};
      send_step(it);
      wait_idle();
   endtask

   // multi path, multi period runs with wealth carried across periods
   task automatic test_carried_wealth();
      write_reg(wpvs_pkg::REG_PATHS, 64'd3);
      write_reg(wpvs_pkg::REG_PERIODS, 64'd3);
      send_run();
      send_run();
      wait_idle();
   endtask

   // register extremes, including clamped counts
   task automatic test_register_extremes();
      write_reg(wpvs_pkg::REG_RISKFREE, 64'd0);
      write_reg(wpvs_pkg::REG_DISCOUNT, 64'h7FFF_FFFF_FFFF);
      write_reg(wpvs_pkg::REG_PENALTY, 64'h0000_8000_0000_0000);
      write_reg(wpvs_pkg::REG_PATHS, 64'd0);
      write_reg(wpvs_pkg::REG_PERIODS, 64'd0);
      send_run();
      wait_idle();
      write_reg(wpvs_pkg::REG_RISKFREE, 64'h7FFF_FFFF_FFFF);
      write_reg(wpvs_pkg::REG_DISCOUNT, 64'd0);
      write_reg(wpvs_pkg::REG_PENALTY, 64'h0000_7FFF_FFFF_FFFF);
      write_reg(wpvs_pkg::REG_PERIODS, 64'd127);
      send_run();
      wait_idle();
      write_reg(wpvs_pkg::REG_RISKFREE, 64'd16944988);
      write_reg(wpvs_pkg::REG_DISCOUNT, 64'd16611105);
      write_reg(wpvs_pkg::REG_PATHS, 64'd2047);
      write_reg(wpvs_pkg::REG_PERIODS, 64'd1);
      send_run();
      wait_idle();
      write_reg(wpvs_pkg::REG_PATHS, 64'd1024);
      write_reg(wpvs_pkg::REG_PERIODS, 64'd64);
      write_reg(wpvs_pkg::REG_PATHS, 64'd1);
      send_run();
      wait_idle();
   endtask

   // random runs under the four idling phases
   task automatic test_random_runs();
      int quota;
      int idle_tab [4] = '{0, 59, 0, 10};
      int stall_tab [4] = '{0, 0, 59, 10};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_tab[ph];
         stall_pct = stall_tab[ph];
         quota = items_sent + 80;
         while (items_sent < quota) begin
            if ($urandom_range(0, 2) == 0) begin
               write_reg(wpvs_pkg::REG_RISKFREE, ($urandom_range(0, 9) == 0)
                         ? {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF
                         : 64'(ONE_Q + $urandom_range(0, 1 << 21) - (1 << 20)));
               write_reg(wpvs_pkg::REG_DISCOUNT, 64'(ONE_Q - $urandom_range(0, 1 << 22)));
               write_reg(wpvs_pkg::REG_PENALTY, 64'(rand_q(1 << 26)));
            end
            write_reg(wpvs_pkg::REG_PATHS, 64'($urandom_range(0, 9) == 0
                                     ? $urandom_range(9, 40) : $urandom_range(1, 8)));
            write_reg(wpvs_pkg::REG_PERIODS, 64'($urandom_range(1, 6)));
            send_run();
            wait_idle();
         end
      end
   endtask

   initial begin
      rf_rate = 16944988;
      disc_factor = 16611105;
      lambda_w = 8388608;
      paths_reg = 1;
      periods_reg = 1;
      foreach (wealth_mem[i]) wealth_mem[i] = 0;
      util_total = 0;
      disc_power = ONE_Q;
      path_pos = 0;
      period_pos = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_carried_wealth();
      test_register_extremes();
      test_random_runs();
      send_idle_pct = 0;
      stall_pct = 0;
      wait_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/wpvs_pkg.sv
rtl/wpvs_ram.sv
rtl/wpvs_mul.sv
rtl/wpvs_div.sv
rtl/wealth_path_value_simulator.sv
bench/tb_wealth_path_value_simulator.sv
